### hw/rtl/symmetric_fir_edge_clamp_macros.svh
// assertion macros for the symmetric fir line filter
// no dependencies, included by files that carry concurrent assertions
`ifndef SYMMETRIC_FIR_EDGE_CLAMP_MACROS_SVH
`define SYMMETRIC_FIR_EDGE_CLAMP_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define SFEC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfec: same-cycle check failed");

// next-cycle implication, checked on every rising edge outside reset
`define SFEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfec: next-cycle check failed");

`endif

### hw/rtl/sfec_pkg.sv
// shared types and constants for the symmetric fir line filter
// no dependencies
package sfec_pkg;

    localparam int COEF_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int FRAC_BITS = 14;
    localparam int ROUND_BIAS = 1 << (FRAC_BITS - 1);

    localparam logic signed [COEF_W-1:0] COEF0_RESET = 16'sd16384;

    // register index of the center coefficient, tap k sits at this plus k
    localparam logic [CFG_IDX_W-1:0] REG_COEF_TAP0 = 3'd0;

    typedef struct packed {
        logic valid;
        logic last;
    } stage_ctl_t;

endpackage

### hw/rtl/sfec_in_if.sv
// sample channel: valid/ready handshake with sample and end-of-line flag
// no dependencies
interface sfec_in_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          end_of_line;

    modport source (output valid, output sample, output end_of_line, input ready);
    modport sink (input valid, input sample, input end_of_line, output ready);
endinterface

### hw/rtl/sfec_out_if.sv
// result channel: valid/ready handshake with filtered sample and last flag
// no dependencies
interface sfec_out_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic                          last_of_line;

    modport source (output valid, output filtered, output last_of_line, input ready);
    modport sink (input valid, input filtered, input last_of_line, output ready);
endinterface

### hw/rtl/sfec_window.sv
// sample window shift line, line position count and end-of-line flush sequencer
// depends on sfec_pkg and sfec_in_if
module sfec_window #(
    parameter int HALF_TAPS   = 7,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    sfec_in_if.sink                       samples,
    input  logic                          s1_free,
    output sfec_pkg::stage_ctl_t          s0_ctl,
    output logic signed [SAMPLE_BITS-1:0] window [2*HALF_TAPS+1]
);
    import sfec_pkg::*;

    localparam int WIN   = 2 * HALF_TAPS + 1;
    localparam int CNT_W = $clog2(HALF_TAPS + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(HALF_TAPS);

    logic signed [SAMPLE_BITS-1:0] window_reg [WIN];
    logic signed [SAMPLE_BITS-1:0] window_next [WIN];
    logic [CNT_W-1:0]              fill_reg, fill_next;
    logic [CNT_W-1:0]              rem_reg, rem_next;
    logic [CNT_W-1:0]              nsave_reg, nsave_next;
    logic                          s0_valid_reg, s0_valid_next;
    logic                          s0_last_reg, s0_last_next;
    logic                          s0_free, flushing, accept, flush_step;
    logic                          emit, emit_last;

    assign s0_free       = !s0_valid_reg || s1_free;
    assign flushing      = (rem_reg != '0);
    assign samples.ready = !flushing && s0_free;
    assign accept        = samples.valid && samples.ready;
    assign flush_step    = flushing && s0_free;

    always_comb
    begin
        window_next = window_reg;
        fill_next   = fill_reg;
        rem_next    = rem_reg;
        nsave_next  = nsave_reg;
        emit        = 1'b0;
        emit_last   = 1'b0;
        if (accept)
        begin
            // first sample of a line floods the window: left edge clamp
            for (int i = 0; i < WIN - 1; i++)
            begin
                window_next[i] = (fill_reg == '0) ? samples.sample : window_reg[i+1];
            end
            window_next[WIN-1] = samples.sample;
            emit = (fill_reg == FULL);
            if (samples.end_of_line)
            begin
                fill_next  = '0;
                rem_next   = FULL;
                nsave_next = fill_reg;
            end
            else
            begin
                fill_next = (fill_reg == FULL) ? FULL : fill_reg + 1'b1;
            end
        end
        else if (flush_step)
        begin
            // repeat the last sample: right edge clamp
            for (int i = 0; i < WIN - 1; i++)
            begin
                window_next[i] = window_reg[i+1];
            end
            window_next[WIN-1] = window_reg[WIN-1];
            rem_next  = rem_reg - 1'b1;
            emit      = ((rem_reg - 1'b1) <= nsave_reg);
            emit_last = (rem_reg == CNT_W'(1));
        end
    end

    assign s0_valid_next = (s0_valid_reg && !s1_free) || emit;
    assign s0_last_next  = emit ? emit_last : s0_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            rem_reg      <= '0;
            nsave_reg    <= '0;
            s0_valid_reg <= 1'b0;
            s0_last_reg  <= 1'b0;
        end
        else
        begin
            fill_reg     <= fill_next;
            rem_reg      <= rem_next;
            nsave_reg    <= nsave_next;
            s0_valid_reg <= s0_valid_next;
            s0_last_reg  <= s0_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
    end

    assign window       = window_reg;
    assign s0_ctl.valid = s0_valid_reg;
    assign s0_ctl.last  = s0_last_reg;

endmodule

### hw/rtl/sfec_mac.sv
// pre-add of mirrored taps and one multiplier per coefficient, registered products
// depends on sfec_pkg
module sfec_mac #(
    parameter int HALF_TAPS   = 7,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  sfec_pkg::stage_ctl_t                                s0_ctl,
    input  logic signed [SAMPLE_BITS-1:0]                       window [2*HALF_TAPS+1],
    input  logic signed [sfec_pkg::COEF_W-1:0]                  coef [HALF_TAPS+1],
    input  logic                                                s2_free,
    output logic                                                s1_free,
    output sfec_pkg::stage_ctl_t                                s1_ctl,
    output logic signed [sfec_pkg::COEF_W+SAMPLE_BITS:0]        prod [HALF_TAPS+1]
);
    import sfec_pkg::*;

    localparam int PAIR_W = SAMPLE_BITS + 1;
    localparam int PROD_W = COEF_W + SAMPLE_BITS + 1;

    logic signed [PAIR_W-1:0] pair [HALF_TAPS+1];
    logic signed [PROD_W-1:0] prod_next [HALF_TAPS+1];
    logic signed [PROD_W-1:0] prod_reg [HALF_TAPS+1];
    logic                     s1_valid_reg, s1_last_reg;
    logic                     s0_adv;

    assign s1_free = !s1_valid_reg || s2_free;
    assign s0_adv  = s0_ctl.valid && s1_free;

    always_comb
    begin
        pair[0]      = PAIR_W'(window[HALF_TAPS]);
        prod_next[0] = coef[0] * window[HALF_TAPS];
        for (int k = 1; k <= HALF_TAPS; k++)
        begin
            pair[k]      = PAIR_W'(window[HALF_TAPS-k]) + PAIR_W'(window[HALF_TAPS+k]);
            prod_next[k] = coef[k] * pair[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else if (s0_adv)
        begin
            s1_valid_reg <= 1'b1;
            s1_last_reg  <= s0_ctl.last;
        end
        else if (s2_free)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_adv)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod         = prod_reg;
    assign s1_ctl.valid = s1_valid_reg;
    assign s1_ctl.last  = s1_last_reg;

endmodule

### hw/rtl/sfec_sum.sv
// product sum, round half up, shift by the fraction bits, saturate, result register
// depends on sfec_pkg and sfec_out_if
module sfec_sum #(
    parameter int HALF_TAPS   = 7,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  sfec_pkg::stage_ctl_t                         s1_ctl,
    input  logic signed [sfec_pkg::COEF_W+SAMPLE_BITS:0] prod [HALF_TAPS+1],
    output logic                                         s2_free,
    sfec_out_if.source                                   results
);
    import sfec_pkg::*;

    localparam int PROD_W = COEF_W + SAMPLE_BITS + 1;
    localparam int ACC_W  = PROD_W + $clog2(HALF_TAPS + 1);
    localparam int SH_W   = ACC_W + 1 - FRAC_BITS;
    localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [ACC_W-1:0]       acc;
    logic signed [ACC_W:0]         rnd;
    logic        [SH_W-1:0]        sh;
    logic        [SH_W-SAMPLE_BITS:0] top_bits;
    logic signed [SAMPLE_BITS-1:0] sat;
    logic signed [SAMPLE_BITS-1:0] filtered_reg;
    logic                          valid_reg, last_reg;
    logic                          s1_adv;

    always_comb
    begin
        acc = '0;
        for (int k = 0; k <= HALF_TAPS; k++)
        begin
            acc = acc + ACC_W'(prod[k]);
        end
        rnd      = (ACC_W+1)'(acc) + (ACC_W+1)'(ROUND_BIAS);
        sh       = rnd[ACC_W:FRAC_BITS];
        top_bits = sh[SH_W-1:SAMPLE_BITS-1];
        if ((&top_bits) || !(|top_bits))
        begin
            sat = sh[SAMPLE_BITS-1:0];
        end
        else
        begin
            sat = sh[SH_W-1] ? SAT_MIN : SAT_MAX;
        end
    end

    assign s2_free = !valid_reg || results.ready;
    assign s1_adv  = s1_ctl.valid && s2_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else if (s1_adv)
        begin
            valid_reg <= 1'b1;
            last_reg  <= s1_ctl.last;
        end
        else if (results.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            filtered_reg <= sat;
        end
    end

    assign results.valid        = valid_reg;
    assign results.filtered     = filtered_reg;
    assign results.last_of_line = last_reg;

endmodule

### hw/rtl/symmetric_fir_edge_clamp.sv
// result path: window register, product register, result register, each held on stall
// throughput: one sample per cycle within a line while the output is not stalled
// end of line: no sample transfer while the HALF_TAPS flush shifts run
// reset: async active low, pipeline empty, start of line, coef_tap0 = 1.0, others zero
// depends on sfec_pkg, sfec_in_if, sfec_out_if, sfec_window, sfec_mac, sfec_sum
module symmetric_fir_edge_clamp #(
    parameter int HALF_TAPS   = 7,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    sfec_in_if.sink                           samples,
    sfec_out_if.source                        results,
    input  logic                              cfg_write_en,
    input  logic [sfec_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sfec_pkg::COEF_W-1:0]       cfg_data
);
    import sfec_pkg::*;

    `include "symmetric_fir_edge_clamp_macros.svh"

    localparam int WIN    = 2 * HALF_TAPS + 1;
    localparam int PROD_W = COEF_W + SAMPLE_BITS + 1;

    // coefficient registers, taps above HALF_TAPS are not stored
    logic signed [COEF_W-1:0]      coef_reg [HALF_TAPS+1];

    // stage 0: window register, stage 1: products, stage 2: result register
    stage_ctl_t                    s0_ctl, s1_ctl;
    logic                          s1_free, s2_free;
    logic signed [SAMPLE_BITS-1:0] window [WIN];
    logic signed [PROD_W-1:0]      prod [HALF_TAPS+1];

    // plain write port, writes beyond the stored taps are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg[0] <= COEF0_RESET;
            for (int k = 1; k <= HALF_TAPS; k++)
            begin
                coef_reg[k] <= '0;
            end
        end
        else if (cfg_write_en)
        begin
            for (int k = 0; k <= HALF_TAPS; k++)
            begin
                if (cfg_index == REG_COEF_TAP0 + CFG_IDX_W'(k))
                begin
                    coef_reg[k] <= cfg_data;
                end
            end
        end
    end

    // window shift line plus flush sequencer: a transfer or flush step per cycle while
    // the window slot is free, each step optionally hands the fresh window to the multipliers
    sfec_window #(
        .HALF_TAPS   (HALF_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .s1_free (s1_free),
        .s0_ctl  (s0_ctl),
        .window  (window)
    );

    // mirrored pre-add and one multiplier per coefficient
    sfec_mac #(
        .HALF_TAPS   (HALF_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .s0_ctl  (s0_ctl),
        .window  (window),
        .coef    (coef_reg),
        .s2_free (s2_free),
        .s1_free (s1_free),
        .s1_ctl  (s1_ctl),
        .prod    (prod)
    );

    // sum, rounding, saturation and the output register that parts the two sides
    sfec_sum #(
        .HALF_TAPS   (HALF_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_sum (
        .clk     (clk),
        .rst_n   (rst_n),
        .s1_ctl  (s1_ctl),
        .prod    (prod),
        .s2_free (s2_free),
        .results (results)
    );

    // a sample transfer only when the window slot is empty or moving on
    `SFEC_ASSERT_IMPLY(a_transfer_needs_slot, clk, rst_n, samples.valid && samples.ready, !s0_ctl.valid || s1_free)
    // an end-of-line transfer always starts a flush that blocks the next sample
    `SFEC_ASSERT_NEXT(a_eol_starts_flush, clk, rst_n, samples.valid && samples.ready && samples.end_of_line, !samples.ready)
    // products held while the result register is stalled
    `SFEC_ASSERT_NEXT(a_products_hold, clk, rst_n, s1_ctl.valid && !s2_free, s1_ctl.valid && $stable(s1_ctl.last))

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// self-checking bench for the symmetric fir line filter with edge clamping
// depends on sfec_pkg, sfec_in_if, sfec_out_if and symmetric_fir_edge_clamp
module tb_top;
    import sfec_pkg::*;

    localparam int HALF_TAPS      = 7;
    localparam int SAMPLE_BITS    = 16;
    localparam int WIN_LEN        = 2 * HALF_TAPS + 1;
    localparam int NUM_COEFS      = 8;
    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 16;
    localparam int DRAIN_CYCLES   = 20;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int LONG_HOLD      = 60;
    localparam int ITEMS_PER_SET  = 55;
    localparam int NUM_SETS       = 8;
    localparam int DIRECTED_ROWS  = 20;
    localparam int unsigned CYCLE_LIMIT = 200000;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;

    // coefficient sets that the random part walks through
    typedef enum int {
        COEF_RANDOM,
        COEF_ALL_MAX,
        COEF_ALL_MIN,
        COEF_SMOOTH,
        COEF_HALF_ONE_TAP,
        COEF_NEGATE
    } coef_set_t;

    localparam coef_set_t SET_ORDER [NUM_SETS] = '{
        COEF_SMOOTH, COEF_ALL_MAX, COEF_RANDOM, COEF_HALF_ONE_TAP,
        COEF_ALL_MIN, COEF_NEGATE, COEF_RANDOM, COEF_SMOOTH
    };

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] filtered;
        logic                          last;
    } fir_result_t;

    // one stimulus row; typed rows carry the last result they cause
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          eol;
        logic                          typed;
        logic signed [SAMPLE_BITS-1:0] exp_filtered;
        logic                          exp_last;
    } line_row_t;

    // reset coefficients give the identity filter, so every result is read
    // straight off the inputs
    localparam line_row_t LINE_ROWS [DIRECTED_ROWS] = '{
        // single-sample line, most negative value
        '{SAMPLE_MIN, 1'b1, 1'b1, SAMPLE_MIN, 1'b1},
        // three-sample line, all results at end of line
        '{SAMPLE_MAX, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{16'sd0,     1'b0, 1'b0, 16'sd0, 1'b0},
        '{-16'sd1,    1'b1, 1'b1, -16'sd1, 1'b1},
        // seven samples: longest line that still gives nothing before its end
        '{16'sd1,     1'b0, 1'b0, 16'sd0, 1'b0},
        '{16'sd2,     1'b0, 1'b0, 16'sd0, 1'b0},
        '{-16'sd2,    1'b0, 1'b0, 16'sd0, 1'b0},
        '{16'sh5555,  1'b0, 1'b0, 16'sd0, 1'b0},
        '{16'shaaaa,  1'b0, 1'b0, 16'sd0, 1'b0},
        '{SAMPLE_MAX, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{SAMPLE_MIN, 1'b1, 1'b1, SAMPLE_MIN, 1'b1},
        // nine samples: the eighth gives the first result, the end flushes eight
        '{16'sd100,   1'b0, 1'b0, 16'sd0, 1'b0},
        '{-16'sd100,  1'b0, 1'b0, 16'sd0, 1'b0},
        '{16'sd4096,  1'b0, 1'b0, 16'sd0, 1'b0},
        '{-16'sd4096, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{SAMPLE_MAX, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{SAMPLE_MIN, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{16'sd7,     1'b0, 1'b0, 16'sd0, 1'b0},
        '{-16'sd7,    1'b0, 1'b1, 16'sd100, 1'b0},
        '{16'sd12345, 1'b1, 1'b1, 16'sd12345, 1'b1}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic                 cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COEF_W-1:0]    cfg_data;

    sfec_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
    sfec_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) result_ch ();

    symmetric_fir_edge_clamp #(
        .HALF_TAPS  (HALF_TAPS),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (sample_ch),
        .results     (result_ch),
        .cfg_write_en(cfg_write_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // shadow of the filter: window, position in the line and coefficients
    logic signed [SAMPLE_BITS-1:0] fir_window [WIN_LEN];
    int unsigned                   line_pos;
    logic signed [COEF_W-1:0]      tap_coef [NUM_COEFS];

    // filtered samples still owed by the block, oldest first
    fir_result_t pending_results [$];

    int unsigned cycle_count = 0;
    int          fail_count = 0;
    int          results_checked = 0;
    int          lines_sent = 0;
    int          samples_sent = 0;
    int          burst_left = 0;
    int          hold_req_cnt = 0;

    always #(CLK_HALF) clk = ~clk;

    // shift one sample in at the newest end of the window
    function automatic void window_shift(input logic signed [SAMPLE_BITS-1:0] x);
        for (int i = 0; i < WIN_LEN - 1; i++)
        begin
            fir_window[i] = fir_window[i + 1];
        end
        fir_window[WIN_LEN - 1] = x;
    endfunction

    // symmetric sum around the window center, round half up, saturate
    function automatic logic signed [SAMPLE_BITS-1:0] window_filter();
        longint acc;
        acc = longint'(tap_coef[0]) * longint'(fir_window[HALF_TAPS]);
        for (int k = 1; k <= HALF_TAPS; k++)
        begin
            acc += longint'(tap_coef[k]) *
                   (longint'(fir_window[HALF_TAPS - k]) + longint'(fir_window[HALF_TAPS + k]));
        end
        acc = (acc + longint'(ROUND_BIAS)) >>> FRAC_BITS;
        if (acc > longint'(SAMPLE_MAX))
            acc = longint'(SAMPLE_MAX);
        if (acc < longint'(SAMPLE_MIN))
            acc = longint'(SAMPLE_MIN);
        return SAMPLE_BITS'(acc);
    endfunction

    // advance the shadow by one accepted sample, queue what it gives
    function automatic int predict_sample(input logic signed [SAMPLE_BITS-1:0] x,
                                          input logic eol);
        int unsigned n;
        int          cnt;
        fir_result_t res;
        n = (line_pos > HALF_TAPS) ? HALF_TAPS : line_pos;
        // first sample of a line fills the window: left-edge clamp
        if (n == 0)
        begin
            for (int i = 0; i < WIN_LEN; i++)
            begin
                fir_window[i] = x;
            end
        end
        window_shift(x);
        if (!eol)
        begin
            line_pos = (n < HALF_TAPS) ? n + 1 : HALF_TAPS;
            if (n >= HALF_TAPS)
            begin
                res.filtered = window_filter();
                res.last = 1'b0;
                pending_results.push_back(res);
                return 1;
            end
            return 0;
        end
        // short line: move the center onto the first sample
        for (int m = n; m < HALF_TAPS; m++)
        begin
            window_shift(x);
        end
        // flush with the last sample repeated: right-edge clamp
        cnt = n + 1;
        for (int i = 0; i < cnt; i++)
        begin
            res.filtered = window_filter();
            res.last = (i == cnt - 1);
            pending_results.push_back(res);
            if (i < cnt - 1)
                window_shift(x);
        end
        line_pos = 0;
        return cnt;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return SAMPLE_BITS'($signed($urandom_range(0, 8)) - 4);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // mostly short and medium lines, a few long ones
    function automatic int random_line_len();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            return $urandom_range(1, HALF_TAPS);
        if (pick < 4)
            return $urandom_range(HALF_TAPS + 1, HALF_TAPS + 2);
        if (pick < 8)
            return $urandom_range(10, 24);
        return $urandom_range(25, 60);
    endfunction

    // sender pacing: bursts of random length, random gaps in between
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    // offer one sample and hold it until the transfer; the handshake is read
    // at the falling edge so it never races the block's own updates
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] x,
                               input logic eol,
                               input logic typed,
                               input logic signed [SAMPLE_BITS-1:0] typed_filtered,
                               input logic typed_last);
        logic        accepted;
        int          produced;
        fir_result_t res;
        sample_ch.valid       <= 1'b1;
        sample_ch.sample      <= x;
        sample_ch.end_of_line <= eol;
        accepted = 1'b0;
        while (!accepted)
        begin
            @(negedge clk);
            accepted = sample_ch.ready;
            @(posedge clk);
        end
        produced = predict_sample(x, eol);
        samples_sent++;
        if (eol)
            lines_sent++;
        // a typed row replaces the last predicted result with its own value
        if (typed && produced > 0)
        begin
            res.filtered = typed_filtered;
            res.last = typed_last;
            void'(pending_results.pop_back());
            pending_results.push_back(res);
        end
    endtask

    // load a whole coefficient set once the block has gone idle
    task automatic load_coef_set(input coef_set_t kind);
        logic signed [COEF_W-1:0] vals [NUM_COEFS];
        int                       pick;
        sample_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // the last flush may still be moving through the pipeline
        repeat (SETTLE_CYCLES) @(posedge clk);
        for (int k = 0; k < NUM_COEFS; k++)
        begin
            vals[k] = '0;
        end
        case (kind)
            COEF_ALL_MAX:
                for (int k = 0; k < NUM_COEFS; k++)
                begin
                    vals[k] = 16'sh7fff;
                end
            COEF_ALL_MIN:
                for (int k = 0; k < NUM_COEFS; k++)
                begin
                    vals[k] = 16'sh8000;
                end
            COEF_SMOOTH:
            begin
                // strong center, small taps on both signs: exact rounding mostly
                vals[0] = COEF_W'($urandom_range(8192, 24576));
                for (int k = 1; k < NUM_COEFS; k++)
                begin
                    vals[k] = COEF_W'($signed($urandom_range(0, 4095)) - 2048);
                end
            end
            COEF_HALF_ONE_TAP:
            begin
                // half center makes odd samples land on the rounding midpoint
                pick = $urandom_range(1, HALF_TAPS);
                vals[0] = 16'sd8192;
                vals[pick] = COEF_W'($urandom);
            end
            COEF_NEGATE:
                // negating the most negative sample must saturate
                vals[0] = -16'sd16384;
            default:
                for (int k = 0; k < NUM_COEFS; k++)
                begin
                    vals[k] = COEF_W'($urandom);
                end
        endcase
        for (int k = 0; k < NUM_COEFS; k++)
        begin
            cfg_write_en <= 1'b1;
            cfg_index    <= REG_COEF_TAP0 + CFG_IDX_W'(k);
            cfg_data     <= vals[k];
            tap_coef[k]   = vals[k];
            @(posedge clk);
        end
        cfg_write_en <= 1'b0;
    endtask

    // receiver: segments of random stall patterns, plus long hold-offs on request
    initial
    begin
        int hold_left;
        int hold_seen;
        int seg_left;
        int mode;
        result_ch.ready = 1'b0;
        hold_left = 0;
        hold_seen = 0;
        seg_left = 0;
        mode = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_req_cnt != hold_seen)
            begin
                // long hold-off: the block fills and must stall its input
                hold_seen = hold_req_cnt;
                hold_left = LONG_HOLD - 1;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    seg_left = $urandom_range(10, 80);
                end
                seg_left--;
                case (mode)
                    0: result_ch.ready <= 1'b1;
                    1: result_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: result_ch.ready <= ($urandom_range(0, 9) < 3);
                    default: result_ch.ready <= seg_left[0];
                endcase
            end
        end
    end

    // result checker: transfers are seen at the falling edge before they happen
    always @(negedge clk)
    begin
        fir_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer: filtered %0d last_of_line %0b",
                       result_ch.filtered, result_ch.last_of_line);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (result_ch.filtered !== want.filtered)
                begin
                    $error("filtered mismatch: expected %0d, actual %0d",
                           want.filtered, result_ch.filtered);
                    fail_count++;
                end
                if (result_ch.last_of_line !== want.last)
                begin
                    $error("last_of_line mismatch: expected %0b, actual %0b",
                           want.last, result_ch.last_of_line);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        int line_len;
        int set_items;
        int drain_wait;
        sample_ch.valid       = 1'b0;
        sample_ch.sample      = '0;
        sample_ch.end_of_line = 1'b0;
        cfg_write_en          = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;

        // shadow starts from the reset state of the block
        for (int i = 0; i < WIN_LEN; i++)
        begin
            fir_window[i] = '0;
        end
        line_pos = 0;
        tap_coef[0] = COEF0_RESET;
        for (int k = 1; k < NUM_COEFS; k++)
        begin
            tap_coef[k] = '0;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed lines run on the reset coefficients
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            pace_sender();
            send_sample(LINE_ROWS[r].sample, LINE_ROWS[r].eol, LINE_ROWS[r].typed,
                        LINE_ROWS[r].exp_filtered, LINE_ROWS[r].exp_last);
        end

        // random lines, one coefficient set after another
        for (int s = 0; s < NUM_SETS; s++)
        begin
            load_coef_set(SET_ORDER[s]);
            if (s == 0 || s == 4)
                hold_req_cnt <= hold_req_cnt + 1;
            set_items = 0;
            while (set_items < ITEMS_PER_SET)
            begin
                line_len = random_line_len();
                // the last line of a set is cut to the samples left
                if (line_len > ITEMS_PER_SET - set_items)
                    line_len = ITEMS_PER_SET - set_items;
                for (int j = 0; j < line_len; j++)
                begin
                    pace_sender();
                    send_sample(random_sample(), j == line_len - 1, 1'b0, '0, 1'b0);
                    set_items++;
                end
            end
        end
        sample_ch.valid <= 1'b0;

        // let the last flush drain, bounded
        drain_wait = 0;
        while (pending_results.size() != 0 && drain_wait < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_wait++;
        end
        if (pending_results.size() != 0)
        begin
            $error("%0d filtered results never arrived", pending_results.size());
            fail_count++;
        end
        // anything arriving now is a stray transfer
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d lines, %0d samples, reset plus %0d coefficient sets",
                 lines_sent, samples_sent, NUM_SETS);
        $display("compared %0d filtered results, %0d failures", results_checked, fail_count);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/sfec_pkg.sv
hw/rtl/sfec_in_if.sv
hw/rtl/sfec_out_if.sv
hw/rtl/sfec_window.sv
hw/rtl/sfec_mac.sv
hw/rtl/sfec_sum.sv
hw/rtl/symmetric_fir_edge_clamp.sv
verif/tb_top.sv
